>>> rtl/core/swfr_pkg.sv
// Shared types, constants and the CRC-8 step for the stop-and-wait frame receiver.
package swfr_pkg;

	// frame geometry
	localparam int FRAME_BYTES   = 18;
	localparam int PAYLOAD_SLOTS = FRAME_BYTES - 3;
	localparam int POS_W         = $clog2(FRAME_BYTES);
	localparam int PAY_AW        = $clog2(PAYLOAD_SLOTS);
	localparam int PAY_CNT_W     = $clog2(PAYLOAD_SLOTS + 1);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	// protocol constants
	localparam logic [7:0] CRC_POLY      = 8'h31;
	localparam logic [3:0] TYPE_ERROR    = 4'hE;
	localparam logic [3:0] TYPE_END      = 4'hF;
	localparam logic [3:0] RESP_ACK      = 4'h1;
	localparam logic [5:0] MARKER_RESET  = 6'h1E;
	localparam logic [1:0] SEQ_RESET     = 2'd1;
	localparam logic [7:0] RESP_RESET    = 8'h12;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_ERROR    = 2'd1;
	localparam logic [1:0] KIND_RESP     = 2'd2;

	// register index (paddr[2])
	localparam logic REG_FRAME_MARKER = 1'b0;

	// one finished frame, as the back end needs it
	typedef struct packed {
		logic [5:0]           marker;
		logic [7:0]           resp_hdr;
		logic [PAY_CNT_W-1:0] pay_cnt;
		logic                 pay_err;
		logic                 done;
	} frame_desc_t;

	// front end writes into the queue
	typedef struct packed {
		logic              push;
		frame_desc_t       desc;
		logic              pay_we;
		logic [PAY_AW-1:0] pay_addr;
		logic [7:0]        pay_data;
	} front_wr_t;

	// back end reads from the queue
	typedef struct packed {
		logic              pop;
		logic [PAY_AW-1:0] rd_addr;
	} back_rd_t;

	// queue status
	typedef struct packed {
		logic              full;
		logic              empty;
		frame_desc_t       head;
		logic [7:0]        rd_data;
	} queue_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PAY,
		BK_RESP
	} back_state_t;

	// CRC-8, MSB first, one byte
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (r[7]) begin
				r = {r[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/core/swfr_front.sv
// Front end: takes frame words, runs the CRC, stores header and payload, classifies frames.
module swfr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            rx_byte,
	input  logic                  frame_start,
	input  logic                  rx_valid,
	output logic                  rx_ready,
	input  logic [5:0]            frame_marker,
	input  logic                  queue_full,
	output swfr_pkg::front_wr_t   wr
);
	import swfr_pkg::*;

	logic [POS_W-1:0]     pos_q;
	logic [7:0]           crc_q;
	logic [7:0]           hdr0_q;
	logic [7:0]           hdr1_q;
	logic [1:0]           exp_seq_q;
	logic [7:0]           resp_hdr_q;

	logic                 acc;
	logic [POS_W-1:0]     pos;
	logic [7:0]           crc_new;
	logic                 last_byte;
	logic                 mark_ok;
	logic                 frame_ok;
	logic [1:0]           seqn;
	logic [3:0]           ftype;
	logic [3:0]           len;
	logic [PAY_CNT_W-1:0] len_sat;
	logic [1:0]           exp_next;
	logic [7:0]           resp_next;
	logic [PAY_CNT_W-1:0] pay_cnt;
	logic [POS_W-1:0]     pay_off;

	// the slot being filled must be free
	assign rx_ready = !queue_full;
	assign acc      = rx_valid && rx_ready;

	// position and CRC, restarted by frame_start
	assign pos       = frame_start ? '0 : pos_q;
	assign crc_new   = crc_byte(frame_start ? 8'h00 : crc_q, rx_byte);
	assign last_byte = (pos == POS_W'(FRAME_BYTES - 1));

	// header fields; both header words are in place by the last word
	assign mark_ok  = (hdr0_q[7:2] == frame_marker);
	assign seqn     = hdr1_q[5:4];
	assign ftype    = hdr1_q[3:0];
	assign len      = {hdr0_q[1:0], hdr1_q[7:6]};
	assign len_sat  = (32'(len) > PAYLOAD_SLOTS) ? PAY_CNT_W'(PAYLOAD_SLOTS)
	                                             : PAY_CNT_W'(len);
	assign frame_ok = mark_ok && (seqn == exp_seq_q) && (crc_new == 8'h00);

	// what an accepted frame releases
	always_comb begin
		pay_cnt = '0;
		if (frame_ok) begin
			if (ftype == TYPE_ERROR) begin
				pay_cnt = PAY_CNT_W'(1);
			end else if (ftype != TYPE_END) begin
				pay_cnt = len_sat;
			end
		end
	end

	assign exp_next  = frame_ok ? exp_seq_q + 2'd1 : exp_seq_q;
	assign resp_next = frame_ok ? {2'b00, exp_seq_q, RESP_ACK} : resp_hdr_q;

	// queue write
	assign pay_off          = pos - POS_W'(2);
	assign wr.push          = acc && last_byte;
	assign wr.desc.marker   = frame_marker;
	assign wr.desc.resp_hdr = resp_next;
	assign wr.desc.pay_cnt  = pay_cnt;
	assign wr.desc.pay_err  = (ftype == TYPE_ERROR);
	assign wr.desc.done     = mark_ok && (ftype == TYPE_END) && (seqn == exp_next - 2'd1);
	assign wr.pay_we        = acc && (pos >= POS_W'(2)) && !last_byte;
	assign wr.pay_addr      = pay_off[PAY_AW-1:0];
	assign wr.pay_data      = rx_byte;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			crc_q      <= 8'h00;
			exp_seq_q  <= SEQ_RESET;
			resp_hdr_q <= RESP_RESET;
		end else if (acc) begin
			pos_q <= last_byte ? '0 : pos + POS_W'(1);
			crc_q <= last_byte ? 8'h00 : crc_new;
			if (last_byte) begin
				exp_seq_q  <= exp_next;
				resp_hdr_q <= resp_next;
			end
		end
	end

	// header words
	always_ff @(posedge clk) begin
		if (acc && pos == POS_W'(0)) begin
			hdr0_q <= rx_byte;
		end
		if (acc && pos == POS_W'(1)) begin
			hdr1_q <= rx_byte;
		end
	end

endmodule

>>> rtl/core/swfr_queue.sv
// Two-slot frame queue: per slot a frame descriptor and its payload bank.
module swfr_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  swfr_pkg::front_wr_t    wr,
	input  swfr_pkg::back_rd_t     rd,
	output swfr_pkg::queue_stat_t  stat
);
	import swfr_pkg::*;

	frame_desc_t       desc_q [QUEUE_DEPTH];
	logic [7:0]        pay_q  [QUEUE_DEPTH][PAYLOAD_SLOTS];
	logic [QCNT_W-1:0] count_q;
	logic              wr_ptr_q;
	logic              rd_ptr_q;

	assign stat.full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty   = (count_q == '0);
	assign stat.head    = desc_q[rd_ptr_q];
	assign stat.rd_data = pay_q[rd_ptr_q][rd.rd_addr];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr.push, rd.pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// slot storage, filled at the write pointer
	always_ff @(posedge clk) begin
		if (wr.push) begin
			desc_q[wr_ptr_q] <= wr.desc;
		end
		if (wr.pay_we) begin
			pay_q[wr_ptr_q][wr.pay_addr] <= wr.pay_data;
		end
	end

endmodule

>>> rtl/core/swfr_back.sv
// Back end: plays out payload or error words, then the 18-word response frame.
module swfr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swfr_pkg::queue_stat_t stat,
	output swfr_pkg::back_rd_t    rd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [1:0]            kind,
	output logic [7:0]            value,
	output logic                  transfer_done,
	output logic                  last
);
	import swfr_pkg::*;

	back_state_t      state_q, state_d;
	logic [POS_W-1:0] idx_q, idx_d;
	logic [7:0]       crc_q, crc_d;
	logic             res_valid_q;
	logic [1:0]       kind_q;
	logic [7:0]       value_q;
	logic             done_q;
	logic             last_q;

	logic             can_issue;
	logic             emit;
	logic [1:0]       emit_kind;
	logic [7:0]       emit_value;
	logic             emit_done;
	logic             emit_last;
	logic [7:0]       resp_byte;
	logic             resp_end;
	logic             pay_end;
	logic             pop;

	assign can_issue = !res_valid_q || res_ready;
	assign rd.rd_addr = idx_q[PAY_AW-1:0];
	assign rd.pop     = pop;
	assign resp_end  = (idx_q == POS_W'(FRAME_BYTES - 1));
	assign pay_end   = (idx_q == POS_W'(stat.head.pay_cnt) - POS_W'(1));

	// response frame word at idx_q
	always_comb begin
		if (idx_q == POS_W'(0)) begin
			resp_byte = {stat.head.marker, 2'b00};
		end else if (idx_q == POS_W'(1)) begin
			resp_byte = stat.head.resp_hdr;
		end else if (resp_end) begin
			resp_byte = crc_byte(crc_q, 8'h00);
		end else begin
			resp_byte = 8'h00;
		end
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		crc_d      = crc_q;
		emit       = 1'b0;
		emit_kind  = KIND_RESP;
		emit_value = resp_byte;
		emit_done  = 1'b0;
		emit_last  = 1'b0;
		pop        = 1'b0;
		case (state_q)
			BK_IDLE: begin
				idx_d = '0;
				crc_d = 8'h00;
				if (!stat.empty) begin
					state_d = (stat.head.pay_cnt != '0) ? BK_PAY : BK_RESP;
				end
			end
			BK_PAY: begin
				if (can_issue) begin
					emit       = 1'b1;
					emit_kind  = stat.head.pay_err ? KIND_ERROR : KIND_PAYLOAD;
					emit_value = stat.rd_data;
					if (pay_end) begin
						state_d = BK_RESP;
						idx_d   = '0;
					end else begin
						idx_d = idx_q + POS_W'(1);
					end
				end
			end
			BK_RESP: begin
				if (can_issue) begin
					emit       = 1'b1;
					emit_last  = resp_end;
					emit_done  = resp_end && stat.head.done;
					crc_d      = crc_byte(crc_q, resp_byte);
					if (resp_end) begin
						pop     = 1'b1;
						state_d = BK_IDLE;
						idx_d   = '0;
					end else begin
						idx_d = idx_q + POS_W'(1);
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			crc_q       <= 8'h00;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			crc_q   <= crc_d;
			if (can_issue) begin
				res_valid_q <= emit;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= emit_kind;
			value_q <= emit_value;
			done_q  <= emit_done;
			last_q  <= emit_last;
		end
	end

	assign res_valid     = res_valid_q;
	assign kind          = kind_q;
	assign value         = value_q;
	assign transfer_done = done_q;
	assign last          = last_q;

endmodule

>>> rtl/core/stop_and_wait_frame_receiver_unit.sv
// Top level of the stop-and-wait frame receiver: config register, front, queue, back.
//
// Usage: frame words enter on rx_byte/frame_start under rx_valid/rx_ready, one per
// cycle; frame_start resynchronizes to word 0. Each 18-word frame is checked for
// marker, sequence number and CRC-8; result words leave on kind/value/
// transfer_done/last under res_valid/res_ready: payload words (or one error code),
// then the 18-word response frame, last set on its final word.
// Flow: the back end passes through its idle state, then plays out the payload or
// error words and the response frame, one result word per cycle while res_ready is
// high; a two-frame queue between the front and back ends lets the front take a
// whole new frame meanwhile, so rx_ready drops only while both queue slots hold
// frames not yet played out.
// If the result side stalls, the output register holds its word, the back end
// waits, and once the queue fills, rx_ready goes low.
// Reset: marker 30, expected sequence 1, response NACK header 0x12, queue empty.
// frame_marker is written over the APB port at byte address 0; the user must write
// it only while idle, as the block itself does not enforce this.
module stop_and_wait_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	input  logic        rx_valid,
	output logic        rx_ready,
	output logic [1:0]  kind,
	output logic [7:0]  value,
	output logic        transfer_done,
	output logic        last,
	output logic        res_valid,
	input  logic        res_ready
);
	import swfr_pkg::*;

	logic [5:0]  frame_marker_q;
	front_wr_t   fwr;
	back_rd_t    brd;
	queue_stat_t qstat;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAME_MARKER) ? {26'd0, frame_marker_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_marker_q <= MARKER_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_MARKER) begin
			frame_marker_q <= pwdata[5:0];
		end
	end

	swfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx_byte),
		.frame_start  (frame_start),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.frame_marker (frame_marker_q),
		.queue_full   (qstat.full),
		.wr           (fwr)
	);

	swfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fwr),
		.rd     (brd),
		.stat   (qstat)
	);

	swfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.stat          (qstat),
		.rd            (brd),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.kind          (kind),
		.value         (value),
		.transfer_done (transfer_done),
		.last          (last)
	);

`ifndef ASSERT_OFF
	// a finished transfer is flagged only on a frame's final word
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && transfer_done |-> last)
		else $error("transfer_done without last");

	// every frame ends with a response word
	a_last_is_resp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last |-> kind == KIND_RESP)
		else $error("last on a non-response word");

	// the front never completes a frame into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		fwr.push |-> !qstat.full)
		else $error("push into full frame queue");

	// a pop always follows a non-empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		brd.pop |-> !qstat.empty)
		else $error("pop from empty frame queue");
`endif

endmodule

>>> test/stop_and_wait_frame_receiver_unit_tb.sv
// Testbench for the stop-and-wait frame receiver: stimulus, result prediction and checking.
`timescale 1ns / 1ps

module stop_and_wait_frame_receiver_unit_tb;
	import swfr_pkg::*;

	localparam logic [2:0] MARKER_ADDR = {REG_FRAME_MARKER, 2'b00};

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} rx_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       done;
		logic       fin;
	} res_word_t;

	// block ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic [7:0]  rx_byte = '0;
	logic        frame_start = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [1:0]  kind;
	logic [7:0]  value;
	logic        transfer_done;
	logic        last;
	logic        res_valid;
	logic        res_ready = 1'b0;

	// words waiting to be sent, and result words owed by the block
	rx_word_t  tx_words[$];
	res_word_t due_words[$];
	int        fail_count = 0;

	// receiver model state
	logic [5:0] marker_cfg = MARKER_RESET;
	logic [4:0] frame_pos = '0;
	logic [7:0] crc_acc = '0;
	logic [7:0] hdr[2];
	logic [7:0] pay[PAYLOAD_SLOTS];
	logic [1:0] exp_seq = SEQ_RESET;
	logic [7:0] resp_hdr = RESP_RESET;

	// frame generator state
	logic [5:0] gen_marker = MARKER_RESET;
	logic [1:0] gen_seq = SEQ_RESET;
	bit         need_start = 1'b0;

	// driver and receiver pacing
	bit         tx_bursty = 1'b1;
	int         burst_left = 0;
	int         gap_left = 0;
	logic       rx_fire_q = 1'b0;
	rx_word_t   tx_cur;
	logic [15:0] ready_pat = 16'hFFFF;
	int         ready_hold = 0;
	res_word_t  got_exp;

	stop_and_wait_frame_receiver_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.rx_byte      (rx_byte),
		.frame_start  (frame_start),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.kind         (kind),
		.value        (value),
		.transfer_done(transfer_done),
		.last         (last),
		.res_valid    (res_valid),
		.res_ready    (res_ready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// CRC-8, poly 0x31, shifted in one message bit at a time
	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			if (r[7] ^ b[i]) begin
				r = {r[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic void owe_word(input logic [1:0] k, input logic [7:0] v,
		input logic d, input logic f);
		res_word_t w;
		w.kind  = k;
		w.value = v;
		w.done  = d;
		w.fin   = f;
		due_words.push_back(w);
	endfunction

	// one received word into the model; a finished frame queues its results
	function automatic void receive_byte(input logic [7:0] b, input logic start);
		logic [7:0] c;
		logic [5:0] mk;
		logic [3:0] flen;
		logic [3:0] ftype;
		logic [1:0] fseq;
		logic [1:0] prev_seq;
		logic       mark_ok;
		logic       done;
		logic [7:0] resp[FRAME_BYTES];
		if (start) begin
			frame_pos = '0;
			crc_acc   = '0;
		end
		if (frame_pos >= FRAME_BYTES) begin
			frame_pos = '0;
		end
		crc_acc = crc8_step(crc_acc, b);
		if (frame_pos < 2) begin
			hdr[frame_pos[0]] = b;
		end else if (frame_pos < FRAME_BYTES - 1) begin
			pay[4'(frame_pos - 5'd2)] = b;
		end
		frame_pos = frame_pos + 5'd1;
		if (frame_pos < FRAME_BYTES) begin
			return;
		end

		// frame complete: decode header and judge it
		frame_pos = '0;
		c         = crc_acc;
		crc_acc   = '0;
		mk        = hdr[0][7:2];
		flen      = {hdr[0][1:0], hdr[1][7:6]};
		fseq      = hdr[1][5:4];
		ftype     = hdr[1][3:0];
		mark_ok   = (mk == marker_cfg);
		if (mark_ok && fseq == exp_seq && c == 8'h00) begin
			if (ftype == TYPE_ERROR) begin
				owe_word(KIND_ERROR, pay[0], 1'b0, 1'b0);
			end else if (ftype != TYPE_END) begin
				for (int i = 0; i < flen && i < PAYLOAD_SLOTS; i++) begin
					owe_word(KIND_PAYLOAD, pay[i], 1'b0, 1'b0);
				end
			end
			resp_hdr = {2'b00, exp_seq, RESP_ACK};
			exp_seq  = exp_seq + 2'd1;
		end
		prev_seq = exp_seq - 2'd1;
		done     = mark_ok && ftype == TYPE_END && fseq == prev_seq;

		// stored response, CRC byte taken over the frame with its last byte zero
		c = 8'h00;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			resp[i] = (i == 0) ? {marker_cfg, 2'b00} : (i == 1) ? resp_hdr : 8'h00;
			c = crc8_step(c, resp[i]);
		end
		resp[FRAME_BYTES-1] = c;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			owe_word(KIND_RESP, resp[i], (i == FRAME_BYTES - 1) && done, i == FRAME_BYTES - 1);
		end
	endfunction

	// build one full frame; fill < 0 gives random payload
	function automatic void queue_frame(input logic [5:0] mk, input logic [1:0] seq,
		input logic [3:0] ftype, input logic [3:0] flen, input bit crc_ok, input int fill);
		logic [7:0] fb[FRAME_BYTES];
		logic [7:0] c;
		rx_word_t   w;
		fb[0] = {mk, flen[3:2]};
		fb[1] = {flen[1:0], seq, ftype};
		c = crc8_step(crc8_step(8'h00, fb[0]), fb[1]);
		for (int i = 2; i < FRAME_BYTES - 1; i++) begin
			fb[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
			c = crc8_step(c, fb[i]);
		end
		fb[FRAME_BYTES-1] = crc_ok ? c : c ^ 8'($urandom_range(1, 255));
		for (int i = 0; i < FRAME_BYTES; i++) begin
			w.data  = fb[i];
			w.start = (i == 0) && (need_start || $urandom_range(0, 1) == 1);
			tx_words.push_back(w);
		end
		need_start = 1'b0;
	endfunction

	// a frame the block should take, advancing the sequence
	function automatic void queue_accepted(input logic [3:0] ftype, input logic [3:0] flen,
		input int fill);
		queue_frame(gen_marker, gen_seq, ftype, flen, 1'b1, fill);
		gen_seq = gen_seq + 2'd1;
	endfunction

	// cut-off frame; the next one must resync
	function automatic void queue_partial(input int n);
		rx_word_t w;
		for (int i = 0; i < n; i++) begin
			w.data  = 8'($urandom);
			w.start = (i == 0);
			tx_words.push_back(w);
		end
		need_start = 1'b1;
	endfunction

	// mostly well-formed frames, some noise
	function automatic void queue_random_frame();
		int       r;
		rx_word_t w;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			queue_accepted(4'($urandom_range(0, 13)), 4'($urandom_range(0, 15)), -1);
		end else if (r < 68) begin
			queue_accepted(TYPE_ERROR, 4'($urandom_range(0, 15)), -1);
		end else if (r < 76) begin
			queue_frame(gen_marker, gen_seq - 2'd1, TYPE_END, 4'($urandom_range(0, 15)),
				1'($urandom_range(0, 1)), -1);
		end else if (r < 82) begin
			queue_frame(gen_marker, gen_seq, 4'($urandom), 4'($urandom_range(0, 15)),
				1'b0, -1);
		end else if (r < 87) begin
			queue_frame(gen_marker ^ 6'($urandom_range(1, 63)), gen_seq, 4'($urandom),
				4'($urandom_range(0, 15)), 1'b1, -1);
		end else if (r < 92) begin
			queue_frame(gen_marker, gen_seq + 2'($urandom_range(1, 3)), 4'($urandom),
				4'($urandom_range(0, 15)), 1'b1, -1);
		end else if (r < 97) begin
			queue_partial($urandom_range(1, FRAME_BYTES - 1));
			queue_accepted(4'($urandom_range(0, 13)), 4'($urandom_range(0, 15)), -1);
		end else begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				w.data  = 8'($urandom);
				w.start = (i == 0);
				tx_words.push_back(w);
			end
			need_start = 1'b0;
		end
	endfunction

	// wait until all words are sent and all results have come, then let the block drain
	task automatic settle();
		while (tx_words.size() != 0 || rx_valid || due_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	// write the marker register while idle, then read it back
	task automatic set_marker(input logic [5:0] mk);
		logic [31:0] rd;
		settle();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MARKER_ADDR;
		pwdata  <= {26'b0, mk};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		marker_cfg = mk;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== {26'b0, mk}) begin
			$error("prdata: expected 0x%08h, got 0x%08h", {26'b0, mk}, rd);
			fail_count++;
		end
		gen_marker = mk;
	endtask

	// word driver: bursts with random gaps, payload held until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else if (!rx_valid || rx_fire_q) begin
			if (gap_left != 0) begin
				gap_left--;
				rx_valid <= 1'b0;
			end else if (tx_words.size() != 0) begin
				tx_cur = tx_words.pop_front();
				rx_byte     <= tx_cur.data;
				frame_start <= tx_cur.start;
				rx_valid    <= 1'b1;
				if (tx_bursty) begin
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 30);
					end
					burst_left--;
					if (burst_left == 0) begin
						gap_left = $urandom_range(1, 8);
					end
				end
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// result side stalls on a rotating pattern, reloaded now and then
	always @(negedge clk) begin
		if (arst_n) begin
			if (ready_hold == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pat = 16'hFFFF;
					1: ready_pat = 16'($urandom) | 16'h0001;
					2: ready_pat = 16'($urandom & $urandom) | 16'h0001;
					default: ready_pat = 16'($urandom) | 16'h8001;
				endcase
				ready_hold = $urandom_range(16, 80);
			end
			ready_hold--;
			res_ready <= ready_pat[0];
			ready_pat = {ready_pat[0], ready_pat[15:1]};
		end
	end

	// monitor: feed taken words to the model, then check taken results
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_fire_q <= 1'b0;
		end else begin
			rx_fire_q <= rx_valid && rx_ready;
			if (rx_valid && rx_ready) begin
				receive_byte(rx_byte, frame_start);
			end
			if (res_valid && res_ready) begin
				if (due_words.size() == 0) begin
					$error("unexpected result word: kind %0d value 0x%02h", kind, value);
					fail_count++;
				end else begin
					got_exp = due_words.pop_front();
					if (kind !== got_exp.kind) begin
						$error("kind: expected %0d, got %0d", got_exp.kind, kind);
						fail_count++;
					end
					if (value !== got_exp.value) begin
						$error("value: expected 0x%02h, got 0x%02h", got_exp.value, value);
						fail_count++;
					end
					if (transfer_done !== got_exp.done) begin
						$error("transfer_done: expected %0b, got %0b", got_exp.done,
							transfer_done);
						fail_count++;
					end
					if (last !== got_exp.fin) begin
						$error("last: expected %0b, got %0b", got_exp.fin, last);
						fail_count++;
					end
				end
			end
		end
	end

	// test sequence
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset marker
		queue_frame(gen_marker, 2'd0, 4'h0, 4'd3, 1'b1, -1);  // wrong sequence, NACK
		queue_accepted(4'h0, 4'd0, -1);                        // no payload
		queue_accepted(4'hD, 4'd15, 255);                      // full payload, all ones
		queue_accepted(4'h3, 4'd15, 0);
		queue_accepted(TYPE_ERROR, 4'd9, -1);
		queue_frame(gen_marker, gen_seq, 4'h1, 4'd5, 1'b0, -1);         // bad CRC
		queue_frame(gen_marker ^ 6'h21, gen_seq, 4'h1, 4'd5, 1'b1, -1); // bad marker
		queue_partial(7);                                               // resync
		queue_accepted(4'h7, 4'd4, -1);
		queue_frame(gen_marker, gen_seq - 2'd1, TYPE_END, 4'd0, 1'b0, -1); // end, bad CRC
		queue_accepted(TYPE_END, 4'd2, -1);                    // accepted end frame
		queue_frame(gen_marker, gen_seq + 2'd1, TYPE_END, 4'd0, 1'b1, -1);
		queue_frame(gen_marker ^ 6'h01, gen_seq - 2'd1, TYPE_END, 4'd0, 1'b1, -1);

		// directed: marker extremes, the first without sender gaps
		set_marker(6'h3F);
		tx_bursty = 1'b0;
		queue_accepted(4'hC, 4'd15, -1);
		queue_frame(gen_marker, gen_seq - 2'd1, TYPE_END, 4'd15, 1'b1, -1);
		set_marker(6'h00);
		tx_bursty = 1'b1;
		queue_accepted(TYPE_ERROR, 4'd0, 0);
		queue_accepted(4'h5, 4'd1, -1);

		// random phases, each under its own marker
		for (int p = 0; p < 6; p++) begin
			set_marker((p == 5) ? MARKER_RESET : 6'($urandom_range(0, 63)));
			tx_bursty = (p % 3 != 1);
			queue_random_frame();
		end

		settle();
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/swfr_pkg.sv
rtl/core/swfr_front.sv
rtl/core/swfr_queue.sv
rtl/core/swfr_back.sv
rtl/core/stop_and_wait_frame_receiver_unit.sv
test/stop_and_wait_frame_receiver_unit_tb.sv
